>>> hdl/cvtg_pkg.sv
// ----------------------------------------------------------------------------
// cvtg_pkg
// Shared types, constants and constant-divisor helpers for the CVT timing
// generator.
// ----------------------------------------------------------------------------
package cvtg_pkg;

    // Divider lane widths (dividend bits = pipeline stages)
    localparam int A_DW = 31;
    localparam int A_SW = 25;
    localparam int D_DW = 29;
    localparam int D_SW = 17;
    localparam int B_DW = 20;
    localparam int B_SW = 31;
    localparam int C_DW = 35;
    localparam int C_SW = 31;

    // Stream payload widths
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 152;
    localparam int M_USER_W = 3;

    // Formula constants
    localparam logic [30:0] NB_NUM_BASE  = 31'd2000000000;
    localparam logic [30:0] NB_NUM_STEP  = 31'd1100000;
    localparam logic [30:0] RB_NUM_BASE  = 31'd1000000000;
    localparam logic [30:0] RB_NUM_STEP  = 31'd460000;
    localparam logic [19:0] NB_VSBP_NUM  = 20'd550000;
    localparam logic [19:0] RB_VBL_NUM   = 20'd460000;
    localparam logic [30:0] PREC_LIMIT   = 31'd33334;
    localparam logic [14:0] PREC_HIGH    = 15'd30000;
    localparam logic [14:0] PREC_LOW     = 15'd20000;
    localparam logic [16:0] PCT_FULL     = 17'd100000;
    localparam logic [14:0] RB_HBLANK    = 15'd160;
    localparam logic [14:0] RB_HSYNC_END = 15'd80;
    localparam logic [14:0] RB_HSYNC     = 15'd32;
    localparam logic [34:0] CLK_SCALE    = 35'd1000000;
    localparam logic [34:0] CLK_MAX      = 35'd134217500;
    localparam logic [24:0] RECIP_250    = 25'd17179869;
    localparam logic [8:0]  CLK_STEP     = 9'd250;

    // Mode geometry carried through the line period divider
    typedef struct packed {
        logic        nz;
        logic        red;
        logic        il;
        logic [14:0] hdisp;
        logic [14:0] vdisp;
        logic [3:0]  vs;
    } cvtg_geom_t;

    // Geometry plus line period
    typedef struct packed {
        cvtg_geom_t  geom;
        logic [30:0] hper;
    } cvtg_line_t;

    // Line period plus horizontal totals
    typedef struct packed {
        cvtg_geom_t  geom;
        logic [30:0] hper;
        logic [14:0] htot;
        logic [14:0] hse;
    } cvtg_hor_t;

    // Finished timing fields waiting for the pixel clock
    typedef struct packed {
        logic        nz;
        logic        red;
        logic        il;
        logic [14:0] hdisp;
        logic [14:0] hss;
        logic [14:0] hse;
        logic [14:0] htot;
        logic [15:0] vdisp;
        logic [15:0] vss;
        logic [15:0] vse;
        logic [15:0] vtot;
    } cvtg_tim_t;

    // floor(x / 1000) for x below 2^19
    function automatic logic [9:0] div1000_19(input logic [18:0] x);
        logic [37:0] p;
        logic [9:0]  q;
        logic [18:0] r;
        p = 38'(x) * 38'(268435);
        q = p[37:28];
        r = x - 19'(19'(q) * 19'd1000);
        if (r >= 19'd1000) begin
            q = q + 10'd1;
        end
        return q;
    endfunction

    // floor(x / 10) for x below 2^17
    function automatic logic [13:0] div10_17(input logic [16:0] x);
        logic [36:0] p;
        logic [13:0] q;
        logic [16:0] r;
        p = 37'(x) * 37'(104857);
        q = p[33:20];
        r = x - 17'(17'(q) * 17'd10);
        if (r >= 17'd10) begin
            q = q + 14'd1;
        end
        return q;
    endfunction

    // floor(x / 25) for x below 2^16
    function automatic logic [11:0] div25_16(input logic [15:0] x);
        logic [31:0] p;
        logic [11:0] q;
        logic [15:0] r;
        p = 32'(x) * 32'(41943);
        q = p[31:20];
        r = x - 16'(16'(q) * 16'd25);
        if (r >= 16'd25) begin
            q = q + 12'd1;
        end
        return q;
    endfunction

    // x is a multiple of 9
    function automatic logic is_mult9(input logic [13:0] x);
        logic [26:0] p;
        logic [10:0] q;
        logic [13:0] r;
        p = 27'(x) * 27'(7281);
        q = p[26:16];
        r = x - 14'(14'(q) * 14'd9);
        if (r >= 14'd9) begin
            r = r - 14'd9;
        end
        return (r == 14'd0);
    endfunction

    // Vsync width from the aspect ratio of the request
    function automatic logic [3:0] vsync_width(input logic [13:0] w, input logic [13:0] h);
        logic [3:0] vs;
        priority if (18'(w) * 18'd3 == 18'(h) * 18'd4) begin
            vs = 4'd4;
        end else if (18'(w) * 18'd9 == 18'(h) * 18'd16) begin
            vs = 4'd5;
        end else if ((18'(w) * 18'd5 == 18'(h) * 18'd8) && !h[0]) begin
            vs = 4'd6;
        end else if (18'(w) * 18'd4 == 18'(h) * 18'd5) begin
            vs = 4'd7;
        end else if ((18'(w) * 18'd3 == 18'(h) * 18'd5) && is_mult9(h)) begin
            vs = 4'd7;
        end else begin
            vs = 4'd10;
        end
        return vs;
    endfunction

endpackage

>>> hdl/cvtg_div_pipe.sv
// ----------------------------------------------------------------------------
// cvtg_div_pipe
// Pipelined restoring divider: one quotient bit per stage, sideband payload
// travels with each transaction.
// ----------------------------------------------------------------------------
module cvtg_div_pipe #(
    parameter int DW = 8,
    parameter int SW = 8,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_dividend,
    input  logic [SW-1:0] in_divisor,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [DW-1:0] out_quotient,
    output logic [PW-1:0] out_payload
);

    logic          vld_reg [DW];
    logic [SW-1:0] rem_reg [DW];
    logic [DW-1:0] acc_reg [DW];
    logic [SW-1:0] dvs_reg [DW];
    logic [PW-1:0] pay_reg [DW];

    for (genvar k = 0; k < DW; k++) begin : g_step
        logic          cur_v;
        logic [SW-1:0] cur_rem;
        logic [SW-1:0] cur_dvs;
        logic [DW-1:0] cur_acc;
        logic [PW-1:0] cur_pay;
        logic [SW:0]   trial;
        logic [SW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign cur_v   = in_valid;
            assign cur_rem = '0;
            assign cur_dvs = in_divisor;
            assign cur_acc = in_dividend;
            assign cur_pay = in_payload;
        end else begin : g_next
            assign cur_v   = vld_reg[k-1];
            assign cur_rem = rem_reg[k-1];
            assign cur_dvs = dvs_reg[k-1];
            assign cur_acc = acc_reg[k-1];
            assign cur_pay = pay_reg[k-1];
        end

        // Shift in the next dividend bit and try the subtraction
        assign trial = {cur_rem, cur_acc[DW-1]};
        assign diff  = trial - {1'b0, cur_dvs};
        assign take  = (trial >= {1'b0, cur_dvs});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? diff[SW-1:0] : trial[SW-1:0];
                acc_reg[k] <= {cur_acc[DW-2:0], take};
                dvs_reg[k] <= cur_dvs;
                pay_reg[k] <= cur_pay;
            end
        end
    end

    assign out_valid    = vld_reg[DW-1];
    assign out_quotient = acc_reg[DW-1];
    assign out_payload  = pay_reg[DW-1];

endmodule

>>> hdl/cvtg_front.sv
// ----------------------------------------------------------------------------
// cvtg_front
// Request capture, active area, margins, vsync width and the line period
// numerator and denominator.
// ----------------------------------------------------------------------------
module cvtg_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cvtg_pkg::S_DATA_W-1:0] in_data,
    input  logic [cvtg_pkg::S_USER_W-1:0] in_user,
    output logic                         out_valid,
    output logic [cvtg_pkg::A_DW-1:0]     out_num,
    output logic [cvtg_pkg::A_SW-1:0]     out_den,
    output cvtg_pkg::cvtg_geom_t         out_geom
);
    import cvtg_pkg::*;

    // Stage 1: captured request
    logic        v1_reg;
    logic [13:0] w1_reg, h1_reg;
    logic [7:0]  rate1_reg;
    logic        red1_reg, il1_reg, mg1_reg;

    // Stage 2: rounded sizes and margin products
    logic        v2_reg, nz2_reg, red2_reg, il2_reg, mg2_reg;
    logic [8:0]  vf2_reg;
    logic [13:0] hround2_reg, vround2_reg;
    logic [18:0] hm2_reg, vm2_reg;
    logic [3:0]  vs2_reg;
    logic        nz2_next;
    logic [8:0]  vf2_next;
    logic [13:0] hround2_next, vround2_next;
    logic [7:0]  rate_eff;

    // Stage 3: margins
    logic        v3_reg, nz3_reg, red3_reg, il3_reg;
    logic [8:0]  vf3_reg;
    logic [13:0] hround3_reg, vround3_reg;
    logic [9:0]  hmar3_reg, vmar3_reg;
    logic [3:0]  vs3_reg;
    logic [9:0]  hmar3_next, vmar3_next;

    // Stage 4: display sizes, numerator, denominator base
    logic        v4_reg;
    cvtg_geom_t  g4_reg, g4_next;
    logic [8:0]  vf4_reg;
    logic [30:0] num4_reg, num4_next;
    logic [15:0] base4_reg, base4_next;

    // Stage 5: denominator
    logic        v5_reg;
    cvtg_geom_t  g5_reg;
    logic [30:0] num5_reg;
    logic [24:0] den5_reg;

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Field rate and active area
    always_comb begin
        nz2_next     = (w1_reg != 14'd0) && (h1_reg != 14'd0);
        rate_eff     = (rate1_reg == 8'd0) ? 8'd60 : rate1_reg;
        vf2_next     = il1_reg ? {rate_eff, 1'b0} : {1'b0, rate_eff};
        vround2_next = il1_reg ? {1'b0, h1_reg[13:1]} : h1_reg;
        hround2_next = {w1_reg[13:3], 3'b000};
    end

    // Margins, the horizontal one rounded to the cell granularity
    always_comb begin
        hmar3_next = 10'd0;
        vmar3_next = 10'd0;
        if (mg2_reg) begin
            hmar3_next = div1000_19(hm2_reg) & 10'h3F8;
            vmar3_next = div1000_19(vm2_reg);
        end
    end

    // Display sizes and the line period fraction
    always_comb begin
        g4_next.nz    = nz3_reg;
        g4_next.red   = red3_reg;
        g4_next.il    = il3_reg;
        g4_next.hdisp = 15'(hround3_reg) + 15'({hmar3_reg, 1'b0});
        g4_next.vdisp = 15'(vround3_reg) + 15'({vmar3_reg, 1'b0});
        g4_next.vs    = vs3_reg;
        if (red3_reg) begin
            num4_next  = RB_NUM_BASE - 31'(31'(vf3_reg) * RB_NUM_STEP);
            base4_next = (g4_next.vdisp == 15'd0) ? 16'd1 : 16'(g4_next.vdisp);
        end else begin
            num4_next  = NB_NUM_BASE - 31'(31'(vf3_reg) * NB_NUM_STEP);
            base4_next = {g4_next.vdisp + 15'd3, il3_reg};
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg      <= in_data[13:0];
            h1_reg      <= in_data[27:14];
            rate1_reg   <= in_data[35:28];
            red1_reg    <= in_user[0];
            il1_reg     <= in_user[1];
            mg1_reg     <= in_user[2];

            nz2_reg     <= nz2_next;
            red2_reg    <= red1_reg;
            il2_reg     <= il1_reg;
            mg2_reg     <= mg1_reg;
            vf2_reg     <= vf2_next;
            hround2_reg <= hround2_next;
            vround2_reg <= vround2_next;
            hm2_reg     <= 19'(19'(hround2_next) * 19'd18);
            vm2_reg     <= 19'(19'(vround2_next) * 19'd18);
            vs2_reg     <= vsync_width(w1_reg, h1_reg);

            nz3_reg     <= nz2_reg;
            red3_reg    <= red2_reg;
            il3_reg     <= il2_reg;
            vf3_reg     <= vf2_reg;
            hround3_reg <= hround2_reg;
            vround3_reg <= vround2_reg;
            hmar3_reg   <= hmar3_next;
            vmar3_reg   <= vmar3_next;
            vs3_reg     <= vs2_reg;

            g4_reg      <= g4_next;
            vf4_reg     <= vf3_reg;
            num4_reg    <= num4_next;
            base4_reg   <= base4_next;

            g5_reg      <= g4_reg;
            num5_reg    <= num4_reg;
            den5_reg    <= 25'(25'(base4_reg) * 25'(vf4_reg));
        end
    end

    assign out_valid = v5_reg;
    assign out_num   = num5_reg;
    assign out_den   = den5_reg;
    assign out_geom  = g5_reg;

endmodule

>>> hdl/cvtg_clk_round.sv
// ----------------------------------------------------------------------------
// cvtg_clk_round
// Pixel clock rounding down to the 250 kHz step, saturation and the
// result register.
// ----------------------------------------------------------------------------
module cvtg_clk_round (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cvtg_pkg::C_DW-1:0]     in_clk,
    input  cvtg_pkg::cvtg_tim_t          in_tim,
    output logic                         out_valid,
    output logic [26:0]                  out_clk,
    output cvtg_pkg::cvtg_tim_t          out_tim
);
    import cvtg_pkg::*;

    logic        v1_reg, v2_reg;
    logic        ge1_reg;
    logic [26:0] x1_reg;
    logic [51:0] p1_reg;
    cvtg_tim_t   t1_reg, t2_reg, t2_next;
    logic [26:0] clk2_reg, clk2_next;
    logic [19:0] q0;
    logic [26:0] rem0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Round down by reciprocal estimate and one correction; zero a null mode
    always_comb begin
        q0   = p1_reg[51:32];
        rem0 = x1_reg - 27'(27'(q0) * 27'(CLK_STEP));
        if (rem0 >= 27'(CLK_STEP)) begin
            rem0 = rem0 - 27'(CLK_STEP);
        end
        clk2_next = ge1_reg ? CLK_MAX[26:0] : (x1_reg - rem0);
        t2_next   = t1_reg;
        if (!t1_reg.nz) begin
            t2_next   = '0;
            clk2_next = 27'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ge1_reg  <= (in_clk >= CLK_MAX);
            x1_reg   <= in_clk[26:0];
            p1_reg   <= 52'(in_clk[26:0]) * 52'(RECIP_250);
            t1_reg   <= in_tim;
            t2_reg   <= t2_next;
            clk2_reg <= clk2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_clk   = clk2_reg;
    assign out_tim   = t2_reg;

endmodule

>>> hdl/cvt_video_timing_generator_unit.sv
// ----------------------------------------------------------------------------
// cvt_video_timing_generator_unit
// CVT timing generator: one mode request in, one full timing result out.
//
//  channel | dir | fields
//  s_      | in  | tdata: width_px, height_lines, refresh_hz
//          |     | tuser: reduced_blank, interlaced_req, margins_req
//  m_      | out | tdata: h_display .. v_total, pixel_clock_khz
//          |     | tuser: valid_res, is_interlaced, sync_polarity
//
// One transaction is accepted per cycle unless m_ stalls. The pipeline has four
// bit-serial divider lanes (31, 29, 20 and 35 stages) plus 12 glue stages.
// Reset clears the valid bits of every stage; no clearing pass is needed.
// A stall on m_ freezes the whole pipeline, s_tready falls with it.
// ----------------------------------------------------------------------------
module cvt_video_timing_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [13:0] width_px, [27:14] height_lines, [35:28] refresh_hz
    input  logic [cvtg_pkg::S_DATA_W-1:0] s_tdata,
    // [0] reduced_blank, [1] interlaced_req, [2] margins_req
    input  logic [cvtg_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [14:0] h_display, [29:15] h_sync_start, [44:30] h_sync_end,
    // [59:45] h_total, [75:60] v_display, [91:76] v_sync_start,
    // [107:92] v_sync_end, [123:108] v_total, [150:124] pixel_clock_khz
    output logic [cvtg_pkg::M_DATA_W-1:0] m_tdata,
    // [0] valid_res, [1] is_interlaced, [2] sync_polarity
    output logic [cvtg_pkg::M_USER_W-1:0] m_tuser
);
    import cvtg_pkg::*;

    logic        en;

    logic        fa_valid;
    logic [A_DW-1:0] fa_num;
    logic [A_SW-1:0] fa_den;
    cvtg_geom_t  fa_geom;

    logic        a_valid;
    logic [A_DW-1:0] a_q;
    cvtg_geom_t  a_geom;

    logic        v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    cvtg_line_t  l6_reg, l7_reg, l6_next;
    logic [14:0] prec6_reg, prec6_next;
    logic [D_DW-1:0] prod7_reg;
    logic [D_SW-1:0] dvs7_reg;

    logic        d_valid;
    logic [D_DW-1:0] d_q;
    cvtg_line_t  d_line;

    cvtg_hor_t   h8_reg, h8_next;
    logic [14:0] hbl;

    logic        b_valid;
    logic [B_DW-1:0] b_q;
    cvtg_hor_t   b_hor;

    cvtg_hor_t   h9_reg;
    logic [20:0] vtot9_reg, vtot9_next;
    logic [11:0] dec9_reg;
    logic [C_DW-1:0] cnum9_reg;
    logic [20:0] vb, vmin;

    cvtg_tim_t   t10_reg, t10_next;
    logic [C_DW-1:0] cnum10_reg;
    logic [C_SW-1:0] hper10_reg;
    logic [14:0] hss0;
    logic [21:0] vtot2;

    logic        c_valid;
    logic [C_DW-1:0] c_q;
    cvtg_tim_t   c_tim;

    logic [26:0] r_clk;
    cvtg_tim_t   r_tim;

    // Advance every stage unless a finished result is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cvtg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_valid(fa_valid),
        .out_num  (fa_num),
        .out_den  (fa_den),
        .out_geom (fa_geom)
    );

    // Line period
    cvtg_div_pipe #(.DW(A_DW), .SW(A_SW), .PW($bits(cvtg_geom_t))) u_div_hper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (fa_valid),
        .in_dividend (fa_num),
        .in_divisor  (fa_den),
        .in_payload  (fa_geom),
        .out_valid   (a_valid),
        .out_quotient(a_q),
        .out_payload (a_geom)
    );

    // Clamp the line period and work out the blank percentage
    always_comb begin
        l6_next.geom = a_geom;
        l6_next.hper = (a_q == '0) ? 31'd1 : a_q;
        if (l6_next.hper < PREC_LIMIT) begin
            prec6_next = PREC_HIGH
                - 15'(div10_17(17'(17'(l6_next.hper[15:0]) * 17'd3)));
        end else begin
            prec6_next = PREC_LOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v6_reg  <= a_valid;
            v7_reg  <= v6_reg;
            v8_reg  <= d_valid;
            v9_reg  <= b_valid;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l6_reg    <= l6_next;
            prec6_reg <= prec6_next;
            l7_reg    <= l6_reg;
            prod7_reg <= D_DW'(D_DW'(l6_reg.geom.hdisp) * D_DW'(prec6_reg));
            dvs7_reg  <= PCT_FULL - D_SW'(prec6_reg);
        end
    end

    // Horizontal blank
    cvtg_div_pipe #(.DW(D_DW), .SW(D_SW), .PW($bits(cvtg_line_t))) u_div_hblank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v7_reg),
        .in_dividend (prod7_reg),
        .in_divisor  (dvs7_reg),
        .in_payload  (l7_reg),
        .out_valid   (d_valid),
        .out_quotient(d_q),
        .out_payload (d_line)
    );

    // Horizontal totals for either blanking style
    always_comb begin
        hbl          = d_q[14:0] & 15'h7FF0;
        h8_next.geom = d_line.geom;
        h8_next.hper = d_line.hper;
        if (d_line.geom.red) begin
            h8_next.htot = d_line.geom.hdisp + RB_HBLANK;
            h8_next.hse  = d_line.geom.hdisp + RB_HSYNC_END;
        end else begin
            h8_next.htot = d_line.geom.hdisp + hbl;
            h8_next.hse  = d_line.geom.hdisp + {1'b0, hbl[14:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h8_reg <= h8_next;
        end
    end

    // Vertical blank lines
    cvtg_div_pipe #(.DW(B_DW), .SW(B_SW), .PW($bits(cvtg_hor_t))) u_div_vblank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v8_reg),
        .in_dividend (h8_reg.geom.red ? RB_VBL_NUM : NB_VSBP_NUM),
        .in_divisor  (h8_reg.hper),
        .in_payload  (h8_reg),
        .out_valid   (b_valid),
        .out_quotient(b_q),
        .out_payload (b_hor)
    );

    // Vertical total, sync back-off and the clock numerator
    always_comb begin
        vb   = 21'(b_q) + 21'd1;
        vmin = b_hor.geom.red ? 21'(b_hor.geom.vs) + 21'd9 : 21'(b_hor.geom.vs) + 21'd3;
        if (vb < vmin) begin
            vb = vmin;
        end
        if (b_hor.geom.red) begin
            vtot9_next = 21'(b_hor.geom.vdisp) + vb;
        end else begin
            vtot9_next = 21'(b_hor.geom.vdisp) + vb + 21'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h9_reg    <= b_hor;
            vtot9_reg <= vtot9_next;
            dec9_reg  <= div25_16({b_hor.htot, 1'b0});
            cnum9_reg <= C_DW'(C_DW'(b_hor.htot) * CLK_SCALE);
        end
    end

    // Sync positions and interlace doubling with saturation
    always_comb begin
        t10_next.nz    = h9_reg.geom.nz;
        t10_next.red   = h9_reg.geom.red;
        t10_next.il    = h9_reg.geom.il;
        t10_next.hdisp = h9_reg.geom.hdisp;
        t10_next.hse   = h9_reg.hse;
        t10_next.htot  = h9_reg.htot;
        hss0 = (h9_reg.hse >= 15'(dec9_reg)) ? h9_reg.hse - 15'(dec9_reg) : 15'd0;
        if (h9_reg.geom.red) begin
            t10_next.hss = h9_reg.hse - RB_HSYNC;
        end else begin
            t10_next.hss = (hss0 & 15'h7FF8) + 15'd8;
        end
        t10_next.vdisp = 16'(h9_reg.geom.vdisp);
        t10_next.vss   = 16'(h9_reg.geom.vdisp) + 16'd3;
        t10_next.vse   = t10_next.vss + 16'(h9_reg.geom.vs);
        vtot2 = h9_reg.geom.il ? {vtot9_reg, 1'b0} : {1'b0, vtot9_reg};
        t10_next.vtot  = (vtot2 > 22'h00FFFF) ? 16'hFFFF : vtot2[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t10_reg    <= t10_next;
            cnum10_reg <= cnum9_reg;
            hper10_reg <= h9_reg.hper;
        end
    end

    // Pixel clock
    cvtg_div_pipe #(.DW(C_DW), .SW(C_SW), .PW($bits(cvtg_tim_t))) u_div_clk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v10_reg),
        .in_dividend (cnum10_reg),
        .in_divisor  (hper10_reg),
        .in_payload  (t10_reg),
        .out_valid   (c_valid),
        .out_quotient(c_q),
        .out_payload (c_tim)
    );

    cvtg_clk_round u_clk_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (c_valid),
        .in_clk   (c_q),
        .in_tim   (c_tim),
        .out_valid(m_tvalid),
        .out_clk  (r_clk),
        .out_tim  (r_tim)
    );

    // Pack the result transaction
    assign m_tdata = {1'b0, r_clk, r_tim.vtot, r_tim.vse, r_tim.vss, r_tim.vdisp,
                      r_tim.htot, r_tim.hse, r_tim.hss, r_tim.hdisp};
    assign m_tuser = {r_tim.red, r_tim.il, r_tim.nz};

endmodule

>>> verif/tb_cvt_video_timing_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_cvt_video_timing_generator_unit
// Self-checking bench for the CVT timing generator. A short table of
// directed mode requests is followed by random requests. Half of the random
// requests use common aspect ratios. Each accepted request is run through a
// local timing calculator and the result is queued. Every result transaction
// is compared field by field with the oldest queued timing. Both stream
// sides idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_cvt_video_timing_generator_unit;
    import cvtg_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic        valid_res;
        logic [14:0] h_display;
        logic [14:0] h_sync_start;
        logic [14:0] h_sync_end;
        logic [14:0] h_total;
        logic [15:0] v_display;
        logic [15:0] v_sync_start;
        logic [15:0] v_sync_end;
        logic [15:0] v_total;
        logic [26:0] pixel_clock_khz;
        logic        is_interlaced;
        logic        sync_polarity;
    } timing_t;

    typedef struct packed {
        logic [13:0] w;
        logic [13:0] h;
        logic [7:0]  rate;
        logic        red;
        logic        il;
        logic        mg;
        logic        zero_exp;
    } mode_req_t;

    localparam int RANDOM_REQS = 680;
    localparam int CALM_AFTER  = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 200;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [S_USER_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;

    timing_t   timing_q[$];
    int        mismatches = 0;
    int        sent = 0;
    int        cycles = 0;
    int        stall_left = 0;
    mode_req_t dir_rows[$];

    cvt_video_timing_generator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Vsync width from the aspect ratio
    function automatic u64_t aspect_vsync(input u64_t h, input u64_t w);
        if (h % 3 == 0 && h * 4 / 3 == w) return 4;
        if (h % 9 == 0 && h * 16 / 9 == w) return 5;
        if (h % 10 == 0 && h * 16 / 10 == w) return 6;
        if (h % 4 == 0 && h * 5 / 4 == w) return 7;
        if (h % 9 == 0 && h * 15 / 9 == w) return 7;
        return 10;
    endfunction

    function automatic u64_t clip(input u64_t v, input u64_t max);
        return (v > max) ? max : v;
    endfunction

    // Full CVT timing for one mode request
    function automatic timing_t cvt_timing(input mode_req_t r);
        timing_t t;
        u64_t w, h, vfield, vround, hround, hmar, vmar, hdisp, vdisp, vs;
        u64_t hper, htot, hse, hss, vss, vse, vtot, clk;
        u64_t num, den, vsbp, sub, prec, hblank, dec, lines, vbl;
        t = '0;
        w = r.w;
        h = r.h;
        if (w == 0 || h == 0) return t;
        vfield = (r.rate != 0) ? u64_t'(r.rate) : 60;
        vround = h;
        if (r.il) begin
            vfield = vfield * 2;
            vround = vround / 2;
        end
        hround = w - (w % 8);
        hmar = 0;
        vmar = 0;
        if (r.mg) begin
            hmar = hround * 18 / 1000;
            hmar = hmar - (hmar % 8);
            vmar = vround * 18 / 1000;
        end
        hdisp = hround + 2 * hmar;
        vdisp = vround + 2 * vmar;
        vs = aspect_vsync(h, w);
        if (!r.red) begin
            num = 64'd1000000000 - 64'd550000 * vfield;
            den = ((vdisp + 3) * 2 + (r.il ? 1 : 0)) * vfield;
            hper = num * 2 / den;
            if (hper == 0) hper = 1;
            vsbp = 64'd550000 / hper + 1;
            if (vsbp < vs + 3) vsbp = vs + 3;
            vtot = vdisp + vsbp + 3;
            sub = 300 * hper / 1000;
            // clamp the blank percentage at its floor of twenty
            if (sub >= 10000) prec = 20000;
            else prec = 30000 - sub;
            hblank = hdisp * prec / (100000 - prec);
            hblank = hblank - (hblank % 16);
            htot = hdisp + hblank;
            hse = hdisp + hblank / 2;
            dec = htot * 8 / 100;
            hss = (hse >= dec) ? hse - dec : 0;
            hss = hss + 8 - (hss % 8);
            vss = vdisp + 3;
            vse = vss + vs;
        end else begin
            num = 64'd1000000000 - 64'd460000 * vfield;
            lines = (vdisp != 0) ? vdisp : 1;
            hper = num / (lines * vfield);
            if (hper == 0) hper = 1;
            vbl = 64'd460000 / hper + 1;
            if (vbl < 3 + vs + 6) vbl = 3 + vs + 6;
            vtot = vdisp + vbl;
            htot = hdisp + 160;
            hse = hdisp + 80;
            hss = hse - 32;
            vss = vdisp + 3;
            vse = vss + vs;
        end
        clk = htot * 1000000 / hper;
        clk = clip(clk - (clk % 250), 134217500);
        if (r.il) vtot = vtot * 2;
        t.valid_res       = 1'b1;
        t.h_display       = 15'(clip(hdisp, 16'h7FFF));
        t.h_sync_start    = 15'(clip(hss, 16'h7FFF));
        t.h_sync_end      = 15'(clip(hse, 16'h7FFF));
        t.h_total         = 15'(clip(htot, 16'h7FFF));
        t.v_display       = 16'(clip(vdisp, 16'hFFFF));
        t.v_sync_start    = 16'(clip(vss, 16'hFFFF));
        t.v_sync_end      = 16'(clip(vse, 16'hFFFF));
        t.v_total         = 16'(clip(vtot, 16'hFFFF));
        t.pixel_clock_khz = 27'(clk);
        t.is_interlaced   = r.il;
        t.sync_polarity   = r.red;
        return t;
    endfunction

    function automatic mode_req_t mk(input int w, input int h, input int rate,
                                     input bit red, input bit il, input bit mg,
                                     input bit zero_exp);
        mode_req_t r;
        r.w = 14'(w);
        r.h = 14'(h);
        r.rate = 8'(rate);
        r.red = red;
        r.il = il;
        r.mg = mg;
        r.zero_exp = zero_exp;
        return r;
    endfunction

    // Random request, half of the time at a common aspect ratio
    function automatic mode_req_t random_mode();
        mode_req_t r;
        int unsigned h, sel;
        r = mk(0, 0, $urandom_range(0, 255), $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        sel = $urandom_range(0, 9);
        h = $urandom_range(1, 9000);
        case (sel)
            0: r.w = 14'(h * 4 / 3);
            1: r.w = 14'(h * 16 / 9);
            2: r.w = 14'(h * 16 / 10);
            3: r.w = 14'(h * 5 / 4);
            4: r.w = 14'(h * 15 / 9);
            5: begin
                r.w = 14'($urandom_range(0, 64));
                h = $urandom_range(0, 16);
            end
            default: begin
                r.w = 14'($urandom);
                h = $urandom_range(0, 16383);
            end
        endcase
        r.h = 14'(h);
        if ($urandom_range(0, 7) == 0) r.rate = 8'd0;
        return r;
    endfunction

    // Drive one request and queue its timing once accepted
    task automatic send_mode(input mode_req_t r, input bit calm);
        int gap;
        timing_t t;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, r.rate, r.h, r.w};
        s_tuser <= {r.mg, r.il, r.red};
        do @(posedge aclk); while (!s_tready);
        t = r.zero_exp ? timing_t'(0) : cvt_timing(r);
        timing_q.push_back(t);
        sent++;
    endtask

    // Hold off the result side in random bursts
    always @(posedge aclk) begin
        if (sent >= CALM_AFTER) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest queued timing
    always @(posedge aclk) begin
        timing_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[14:0], m_tdata[29:15], m_tdata[44:30],
                   m_tdata[59:45], m_tdata[75:60], m_tdata[91:76], m_tdata[107:92],
                   m_tdata[123:108], m_tdata[150:124], m_tuser[1], m_tuser[2]};
            if (timing_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, got);
                mismatches++;
            end else begin
                want = timing_q.pop_front();
                if (got.valid_res !== want.valid_res) begin
                    $display("%0t: valid_res exp %0d got %0d", $time,
                             want.valid_res, got.valid_res);
                    mismatches++;
                end
                if (got.h_display !== want.h_display) begin
                    $display("%0t: h_display exp %0d got %0d", $time,
                             want.h_display, got.h_display);
                    mismatches++;
                end
                if (got.h_sync_start !== want.h_sync_start) begin
                    $display("%0t: h_sync_start exp %0d got %0d", $time,
                             want.h_sync_start, got.h_sync_start);
                    mismatches++;
                end
                if (got.h_sync_end !== want.h_sync_end) begin
                    $display("%0t: h_sync_end exp %0d got %0d", $time,
                             want.h_sync_end, got.h_sync_end);
                    mismatches++;
                end
                if (got.h_total !== want.h_total) begin
                    $display("%0t: h_total exp %0d got %0d", $time,
                             want.h_total, got.h_total);
                    mismatches++;
                end
                if (got.v_display !== want.v_display) begin
                    $display("%0t: v_display exp %0d got %0d", $time,
                             want.v_display, got.v_display);
                    mismatches++;
                end
                if (got.v_sync_start !== want.v_sync_start) begin
                    $display("%0t: v_sync_start exp %0d got %0d", $time,
                             want.v_sync_start, got.v_sync_start);
                    mismatches++;
                end
                if (got.v_sync_end !== want.v_sync_end) begin
                    $display("%0t: v_sync_end exp %0d got %0d", $time,
                             want.v_sync_end, got.v_sync_end);
                    mismatches++;
                end
                if (got.v_total !== want.v_total) begin
                    $display("%0t: v_total exp %0d got %0d", $time,
                             want.v_total, got.v_total);
                    mismatches++;
                end
                if (got.pixel_clock_khz !== want.pixel_clock_khz) begin
                    $display("%0t: pixel_clock_khz exp %0d got %0d", $time,
                             want.pixel_clock_khz, got.pixel_clock_khz);
                    mismatches++;
                end
                if (got.is_interlaced !== want.is_interlaced) begin
                    $display("%0t: is_interlaced exp %0d got %0d", $time,
                             want.is_interlaced, got.is_interlaced);
                    mismatches++;
                end
                if (got.sync_polarity !== want.sync_polarity) begin
                    $display("%0t: sync_polarity exp %0d got %0d", $time,
                             want.sync_polarity, got.sync_polarity);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // zero sizes give an all-zero, invalid result
        dir_rows.push_back(mk(0, 480, 60, 0, 0, 0, 1));
        dir_rows.push_back(mk(640, 0, 60, 1, 1, 1, 1));
        dir_rows.push_back(mk(0, 0, 0, 1, 1, 1, 1));
        // field extremes and saturation
        dir_rows.push_back(mk(16383, 16383, 255, 1, 1, 1, 0));
        dir_rows.push_back(mk(16383, 16383, 255, 0, 0, 1, 0));
        dir_rows.push_back(mk(16383, 1, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk(1, 16383, 0, 0, 1, 0, 0));
        // width below the 8-pixel granule
        dir_rows.push_back(mk(7, 100, 60, 0, 0, 0, 0));
        dir_rows.push_back(mk(3, 5, 75, 1, 0, 1, 0));
        // each aspect ratio
        dir_rows.push_back(mk(640, 480, 60, 0, 0, 0, 0));
        dir_rows.push_back(mk(1920, 1080, 60, 0, 1, 0, 0));
        dir_rows.push_back(mk(1280, 800, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(1280, 1024, 85, 0, 0, 1, 0));
        dir_rows.push_back(mk(1800, 1080, 50, 1, 1, 1, 0));
        // reduced blanking with no active lines
        dir_rows.push_back(mk(1024, 1, 60, 1, 1, 0, 0));
        // low and high field rates, the low one driving the blank percentage to its floor
        dir_rows.push_back(mk(64, 2, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk(800, 600, 255, 0, 1, 1, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) send_mode(dir_rows[i], 1'b0);
        for (int n = 0; n < RANDOM_REQS; n++) send_mode(random_mode(), sent >= CALM_AFTER);
        s_tvalid <= 1'b0;
        while (timing_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cvtg_pkg.sv
hdl/cvtg_div_pipe.sv
hdl/cvtg_front.sv
hdl/cvtg_clk_round.sv
hdl/cvt_video_timing_generator_unit.sv
verif/tb_cvt_video_timing_generator_unit.sv
